/* design/priority_then_round_robin_scheduler_core_assert.svh */
// Assertion macros for the two-level scheduler core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef PRIORITY_THEN_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_THEN_ROUND_ROBIN_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/prts_pkg.sv */
// Shared types and constants of the two-level scheduler core.
// No dependencies; imported by the input and output interfaces and the top level.
`default_nettype none

package prts_pkg;

    // Item function codes.
    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_TICK  = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    localparam logic [9:0]  PRIO_LIMIT  = 10'd1000;
    localparam logic [23:0] TICK_MAX    = 24'hFFFFFF;
    localparam logic [3:0]  QUANTUM_RST = 4'd4;
    localparam logic [3:0]  SLICE_MAX   = 4'd15;

    // One process table entry.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [9:0]  prio;
        logic        demoted;
        logic [3:0]  slice;
    } t_entry;

    // One result item.
    typedef struct packed {
        logic        load_status;
        logic        ran_valid;
        logic        ran_from_queue;
        logic [15:0] ran_id;
        logic        done_valid;
        logic [15:0] done_id;
        logic [23:0] completion_time;
        logic [23:0] waiting_time;
        logic [23:0] turnaround_time;
        logic        all_finished;
    } t_result;

endpackage

`default_nettype wire

/* design/prts_if.sv */
// Channel interfaces of the two-level scheduler core: input items,
// result items and the quantum write channel. Depends on prts_pkg.
`default_nettype none

interface prts_in_if import prts_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [9:0]  priority_level;

    modport source (output valid, func, proc_id, arrival_time, burst_time,
                    priority_level, input ready);
    modport sink   (input valid, func, proc_id, arrival_time, burst_time,
                    priority_level, output ready);
endinterface

interface prts_out_if import prts_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        load_status;
    logic        ran_valid;
    logic        ran_from_queue;
    logic [15:0] ran_id;
    logic        done_valid;
    logic [15:0] done_id;
    logic [23:0] completion_time;
    logic [23:0] waiting_time;
    logic [23:0] turnaround_time;
    logic        all_finished;

    modport source (output valid, load_status, ran_valid, ran_from_queue, ran_id,
                    done_valid, done_id, completion_time, waiting_time,
                    turnaround_time, all_finished, input ready);
    modport sink   (input valid, load_status, ran_valid, ran_from_queue, ran_id,
                    done_valid, done_id, completion_time, waiting_time,
                    turnaround_time, all_finished, output ready);
endinterface

interface prts_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* design/priority_then_round_robin_scheduler_core.sv */
// Two-level scheduler core: priority stage over a round-robin FIFO.
// Depends on prts_pkg, prts_if.sv and the assertion macro header.
//
//  channel  | dir | handshake    | carries
//  ---------+-----+--------------+--------------------------------------
//  i_in     | in  | valid/ready  | func, process entry fields
//  o_out    | out | valid/ready  | load, service and completion results
//  i_cfg    | in  | valid/ready  | quantum (always ready)
//
// For a tick item, the process table sits in one memory with one registered
// read port that is scanned one entry per cycle, then at most two entries are
// read, modified and written back one after another. Load, clear and unknown
// items go straight to the output state. Reset is synchronous and needs no
// clearing pass. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted, and a result that cannot
// enter the occupied output register holds the sequencer.
`default_nettype none
`include "priority_then_round_robin_scheduler_core_assert.svh"

module priority_then_round_robin_scheduler_core
    import prts_pkg::*;
#(
    parameter int MAX_PROCS = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    prts_in_if.sink   i_in,
    prts_out_if.source o_out,
    prts_cfg_if.sink  i_cfg
);

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_PROCS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_PROCS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DEC, S_H, S_ROT, S_LCHK, S_LS, S_BCHK, S_BEST,
        S_TEND, S_OUT
    } t_state;

    t_state          r_state;
    logic [3:0]      r_quantum;
    logic [CW-1:0]   r_pc, r_fin, r_fcnt, r_scan_i;
    logic [AW-1:0]   r_head, r_tail, r_ls, r_best, r_pidx;
    logic            r_lsv, r_found, r_pv, r_ov;
    logic [9:0]      r_best_pri;
    logic [23:0]     r_tick;
    t_result         r_res, r_out;

    // Memories.
    t_entry          r_tab [MAX_PROCS];
    logic [AW-1:0]   r_fmem [MAX_PROCS];
    t_entry          r_q;
    logic [AW-1:0]   r_fq;

    logic [AW-1:0]   w_ra, w_wa, w_fwa;
    logic            w_we, w_fwe, w_pop;
    t_entry          w_wd;
    logic [AW-1:0]   w_fwd;

    logic            w_in_acc;
    logic [15:0]     w_rem_dec;
    logic [3:0]      w_slice_inc;
    logic [15:0]     w_served;
    logic            w_slice_full, w_prio_full;
    logic [23:0]     w_ct, w_ab, w_arr;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // Entry arithmetic on the word just read.
    always_comb begin
        w_rem_dec    = r_q.remaining - 16'd1;
        w_slice_inc  = (r_q.slice < SLICE_MAX) ? r_q.slice + 4'd1 : r_q.slice;
        w_served     = r_q.burst - w_rem_dec;
        w_slice_full = (w_slice_inc >= r_quantum);
        w_prio_full  = (w_served >= {12'd0, r_quantum});
        w_ct  = (r_tick == TICK_MAX) ? TICK_MAX : r_tick + 24'd1;
        w_arr = {8'd0, r_q.arrival};
        w_ab  = w_arr + {8'd0, r_q.burst};
    end

    // Memory port control by state.
    always_comb begin
        w_ra  = r_scan_i[AW-1:0];
        w_we  = 1'b0;
        w_wa  = r_fq;
        w_wd  = r_q;
        w_fwe = 1'b0;
        w_fwa = r_tail;
        w_fwd = r_fq;
        w_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_wa = r_pc[AW-1:0];
                w_wd = '{id: i_in.proc_id, arrival: i_in.arrival_time,
                         burst: i_in.burst_time, remaining: i_in.burst_time,
                         prio: i_in.priority_level, demoted: 1'b0, slice: 4'd0};
                w_we = w_in_acc && (t_func'(i_in.func) == FN_LOAD) && (r_pc < FULL_CNT);
            end
            S_DEC:  w_ra = r_fq;
            S_H: begin
                w_wa = r_fq;
                if (r_q.remaining != 16'd0) begin
                    w_we = 1'b1;
                    w_wd.remaining = w_rem_dec;
                    w_wd.slice = (w_rem_dec != 16'd0 && w_slice_full) ? 4'd0 : w_slice_inc;
                    if (w_rem_dec == 16'd0) begin
                        w_pop = 1'b1;
                    end else if (w_slice_full) begin
                        w_pop = 1'b1;
                        w_fwe = 1'b1;
                    end
                end else begin
                    w_pop = 1'b1;
                end
            end
            S_ROT: begin
                if (r_q.slice != 4'd0) begin
                    w_pop = 1'b1;
                    w_fwe = 1'b1;
                end
            end
            S_LCHK: w_ra = r_ls;
            S_LS: begin
                w_wa = r_ls;
                w_wd.demoted = 1'b1;
                w_we = !r_q.demoted;
                w_fwd = r_ls;
                w_fwe = !r_q.demoted && (r_fcnt < FULL_CNT);
            end
            S_BCHK: w_ra = r_best;
            S_BEST: begin
                w_wa = r_best;
                w_we = 1'b1;
                w_wd.remaining = w_rem_dec;
                w_wd.demoted = (w_rem_dec == 16'd0) || w_prio_full;
                w_fwd = r_best;
                w_fwe = (w_rem_dec != 16'd0) && w_prio_full && (r_fcnt < FULL_CNT);
            end
            default: ;
        endcase
    end

    // Process table and FIFO memories, registered reads.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tab[w_wa] <= w_wd;
        end
        r_q <= r_tab[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_fmem[w_fwa] <= w_fwd;
        end
        r_fq <= r_fmem[r_head];
    end

    // Sequencer, counters and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_quantum  <= QUANTUM_RST;
            r_pc       <= '0;
            r_fin      <= '0;
            r_fcnt     <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_tick     <= '0;
            r_ls       <= '0;
            r_lsv      <= 1'b0;
            r_ov       <= 1'b0;
            r_scan_i   <= '0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_best     <= '0;
            r_best_pri <= PRIO_LIMIT;
            r_pidx     <= '0;
            r_res      <= '0;
            r_out      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_quantum <= i_cfg.data;
            end
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            // FIFO pointers follow the pop and push strobes.
            if (w_pop) begin
                r_head <= wrap_next(r_head);
            end
            if (w_fwe) begin
                r_tail <= wrap_next(r_tail);
            end
            r_fcnt <= r_fcnt + CW'(w_fwe) - CW'(w_pop);

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_res      <= '0;
                        r_scan_i   <= '0;
                        r_pv       <= 1'b0;
                        r_found    <= 1'b0;
                        r_best     <= '0;
                        r_best_pri <= PRIO_LIMIT;
                        r_state    <= S_OUT;
                        case (t_func'(i_in.func))
                            FN_LOAD: begin
                                if (r_pc >= FULL_CNT) begin
                                    r_res.load_status <= 1'b1;
                                end else begin
                                    r_pc <= r_pc + CW'(1);
                                    if (i_in.burst_time == 16'd0) begin
                                        r_fin <= r_fin + CW'(1);
                                    end
                                end
                            end
                            FN_TICK:  r_state <= S_SCAN;
                            FN_CLEAR: begin
                                r_pc   <= '0;
                                r_fin  <= '0;
                                r_fcnt <= '0;
                                r_head <= '0;
                                r_tail <= '0;
                                r_tick <= '0;
                                r_ls   <= '0;
                                r_lsv  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                // One entry read per cycle; compare the word read last cycle.
                S_SCAN: begin
                    if (r_scan_i < r_pc) begin
                        r_scan_i <= r_scan_i + CW'(1);
                        r_pv     <= 1'b1;
                        r_pidx   <= r_scan_i[AW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && ({8'd0, r_q.arrival} <= r_tick) &&
                        (r_q.remaining != 16'd0) && !r_q.demoted &&
                        (r_q.prio < r_best_pri)) begin
                        r_best_pri <= r_q.prio;
                        r_best     <= r_pidx;
                        r_found    <= 1'b1;
                    end
                    if (!r_pv && (r_scan_i >= r_pc)) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (!r_found && r_fcnt != '0) begin
                        r_state <= S_H;
                    end else if (r_found && r_fcnt != '0 && !r_lsv) begin
                        r_state <= S_ROT;
                    end else begin
                        r_state <= S_LCHK;
                    end
                end
                // Round-robin stage serves the FIFO head.
                S_H: begin
                    r_lsv <= 1'b0;
                    if (r_q.remaining != 16'd0) begin
                        r_res.ran_valid      <= 1'b1;
                        r_res.ran_from_queue <= 1'b1;
                        r_res.ran_id         <= r_q.id;
                        if (w_rem_dec == 16'd0) begin
                            r_res.done_valid      <= 1'b1;
                            r_res.done_id         <= r_q.id;
                            r_res.completion_time <= w_ct;
                            r_res.waiting_time    <= (w_ct >= w_ab) ? w_ct - w_ab : 24'd0;
                            r_res.turnaround_time <= (w_ct >= w_arr) ? w_ct - w_arr : 24'd0;
                            r_fin <= r_fin + CW'(1);
                        end
                    end
                    r_state <= S_TEND;
                end
                S_ROT:  r_state <= S_LCHK;
                S_LCHK: begin
                    if (r_lsv && (!r_found || r_best != r_ls)) begin
                        r_state <= S_LS;
                    end else begin
                        r_state <= S_BCHK;
                    end
                end
                S_LS:   r_state <= S_BCHK;
                S_BCHK: begin
                    r_lsv   <= r_found;
                    r_ls    <= r_found ? r_best : '0;
                    r_state <= r_found ? S_BEST : S_TEND;
                end
                // Priority stage serves the chosen entry.
                S_BEST: begin
                    r_res.ran_valid <= 1'b1;
                    r_res.ran_id    <= r_q.id;
                    if (w_rem_dec == 16'd0) begin
                        r_res.done_valid      <= 1'b1;
                        r_res.done_id         <= r_q.id;
                        r_res.completion_time <= w_ct;
                        r_res.waiting_time    <= (w_ct >= w_ab) ? w_ct - w_ab : 24'd0;
                        r_res.turnaround_time <= (w_ct >= w_arr) ? w_ct - w_arr : 24'd0;
                        r_fin <= r_fin + CW'(1);
                    end
                    r_state <= S_TEND;
                end
                S_TEND: begin
                    if (r_tick != TICK_MAX) begin
                        r_tick <= r_tick + 24'd1;
                    end
                    r_state <= S_OUT;
                end
                // Hand the result over once the output register is free.
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_out <= r_res;
                        r_out.all_finished <= (r_fin == r_pc);
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.load_status     = r_out.load_status;
    assign o_out.ran_valid       = r_out.ran_valid;
    assign o_out.ran_from_queue  = r_out.ran_from_queue;
    assign o_out.ran_id          = r_out.ran_id;
    assign o_out.done_valid      = r_out.done_valid;
    assign o_out.done_id         = r_out.done_id;
    assign o_out.completion_time = r_out.completion_time;
    assign o_out.waiting_time    = r_out.waiting_time;
    assign o_out.turnaround_time = r_out.turnaround_time;
    assign o_out.all_finished    = r_out.all_finished;

    // Each slot sits in the FIFO at most once, and only loaded slots finish.
    `PRTS_ASSERT_NOW(a_fifo_bound, 1'b1, r_fcnt <= r_pc, "FIFO holds more than the table")
    `PRTS_ASSERT_NOW(a_fin_bound, 1'b1, r_fin <= r_pc, "more finished than loaded")
    `PRTS_ASSERT_NEXT(a_busy, w_in_acc, !i_in.ready, "item taken while busy")
    `PRTS_ASSERT_NEXT(a_out_hold, r_ov && !o_out.ready, r_ov && $stable(r_out), "result lost")

endmodule

`default_nettype wire
